// ===== rtl/acws_pkg.sv =====
// Shared types and constants for the 2D acoustic wave stencil block.
// Holds the payload structs, config register indexes and the front/back queue entry.
// No dependencies.
`default_nettype none

package acws_pkg;

    localparam int VAL_W       = 32;
    localparam int IDX_W       = 10;
    localparam int GRID_W      = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int GRID_CMP_W  = 13;   // holds grid sizes up to 4096
    localparam int MIN_GRID    = 7;
    localparam int ROW_BANKS   = 4;
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LAPLACIAN_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COURANT_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ROW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_COL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS      = 3'd6;

    // Update rule for one grid point
    localparam logic [1:0] KIND_EDGE  = 2'd0;
    localparam logic [1:0] KIND_ZERO  = 2'd1;
    localparam logic [1:0] KIND_INNER = 2'd2;

    typedef struct packed {
        logic signed [VAL_W-1:0] cur_value;
        logic signed [VAL_W-1:0] prev_value;
        logic signed [VAL_W-1:0] source_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] next_value;
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic                    run_last;
        logic                    frame_last;
    } out_item_t;

    typedef struct packed {
        logic [GRID_W-1:0] grid_rows;
        logic [GRID_W-1:0] grid_cols;
        logic [IDX_W-1:0]  source_row;
        logic [IDX_W-1:0]  source_col;
    } geom_cfg_t;

    typedef struct packed {
        logic [VAL_W-1:0] laplacian_gain;
        logic [VAL_W-1:0] courant_gain;
        logic [VAL_W-1:0] source_gain;
    } gain_cfg_t;

    // One request from front to back: the window around point (row-2, col)
    typedef struct packed {
        logic signed [VAL_W-1:0] up2;
        logic signed [VAL_W-1:0] up1;
        logic signed [VAL_W-1:0] ctr;
        logic signed [VAL_W-1:0] dn1;
        logic signed [VAL_W-1:0] dn2;
        logic signed [VAL_W-1:0] lf2;
        logic signed [VAL_W-1:0] lf1;
        logic signed [VAL_W-1:0] rt1;
        logic signed [VAL_W-1:0] rt2;
        logic signed [VAL_W-1:0] prv;
        logic signed [VAL_W-1:0] smp;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic                    last_row;
        logic                    frame_last;
        logic [1:0]              main_kind;
        logic                    main_src;
    } q_entry_t;

endpackage

`default_nettype wire

// ===== rtl/acoustic_wave_stencil_2d.sv =====
// Top level of the 2D acoustic wave stencil: config registers, front end,
// request queue and arithmetic back end. Uses acws_pkg, acws_front, acws_queue, acws_back.
//
//  channel | signals                          | request
//  --------+----------------------------------+-----------------------------------
//  in      | in_valid, in_stall, in_data      | one grid point, raster order
//  out     | out_valid, out_stall, out_data   | next value of one grid point
//  cfg     | cfg_write, cfg_index, cfg_data   | one register write, no read-back
//
// One point per cycle in, one result per cycle out, while neither side stalls. A last-row
// point gives three results, so on that row the output port sets the pace.
// Reset clears positions and the pipeline; row buffers are not cleared.
// Output stall freezes the back end; the front keeps taking points until the queue fills.
`default_nettype none

module acoustic_wave_stencil_2d #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 1024,
    parameter int EDGE_WIDTH = 3
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [acws_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [acws_pkg::VAL_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  acws_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output acws_pkg::out_item_t                  out_data
);
    import acws_pkg::*;

    geom_cfg_t geom_reg;
    gain_cfg_t gain_reg;

    logic     q_push, q_full, q_pop, q_head_valid;
    q_entry_t q_push_data, q_head_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg.laplacian_gain <= '0;
            gain_reg.courant_gain   <= '0;
            gain_reg.source_gain    <= '0;
            geom_reg.source_row     <= '0;
            geom_reg.source_col     <= '0;
            geom_reg.grid_rows      <= GRID_W'(300);
            geom_reg.grid_cols      <= GRID_W'(300);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LAPLACIAN_GAIN: gain_reg.laplacian_gain <= cfg_data;
                REG_COURANT_GAIN:   gain_reg.courant_gain   <= cfg_data;
                REG_SOURCE_GAIN:    gain_reg.source_gain    <= cfg_data;
                REG_SOURCE_ROW:     geom_reg.source_row     <= cfg_data[IDX_W-1:0];
                REG_SOURCE_COL:     geom_reg.source_col     <= cfg_data[IDX_W-1:0];
                REG_GRID_ROWS:      geom_reg.grid_rows      <= cfg_data[GRID_W-1:0];
                REG_GRID_COLS:      geom_reg.grid_cols      <= cfg_data[GRID_W-1:0];
                default:            ;
            endcase
        end
    end

    acws_front #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .EDGE_WIDTH (EDGE_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .geom     (geom_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_push   (q_push),
        .q_data   (q_push_data),
        .q_full   (q_full)
    );

    acws_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_data)
    );

    acws_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .gains      (gain_reg),
        .head_valid (q_head_valid),
        .head_data  (q_head_data),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

// ===== rtl/acws_front.sv =====
// Front end: raster position tracking, row buffers and window assembly.
// Pushes one classified window request per point from row 2 on into the queue. Uses acws_pkg.
`default_nettype none

module acws_front #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_ROWS   = 1024,
    parameter int EDGE_WIDTH = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  acws_pkg::geom_cfg_t geom,
    input  logic                in_valid,
    output logic                in_stall,
    input  acws_pkg::in_item_t  in_data,
    output logic                q_push,
    output acws_pkg::q_entry_t  q_data,
    input  logic                q_full
);
    import acws_pkg::*;

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int BW = $clog2(ROW_BANKS);
    localparam int GW = GRID_CMP_W;
    localparam logic [GW-1:0] EDGE_G = GW'(EDGE_WIDTH);

    // Row buffers: four rows of current values, two rows of previous values
    logic signed [VAL_W-1:0] cur_rows_mem  [ROW_BANKS][MAX_COLS];
    logic signed [VAL_W-1:0] prev_rows_mem [2][MAX_COLS];

    logic [CW-1:0] col_pos_reg, col_pos_next;
    logic [RW-1:0] row_pos_reg, row_pos_next;
    logic          s1_valid_reg, s1_valid_next;

    logic signed [VAL_W-1:0] rd_a_reg [ROW_BANKS];
    logic signed [VAL_W-1:0] rd_b_reg [ROW_BANKS];
    logic signed [VAL_W-1:0] prv_rd_reg;
    logic signed [VAL_W-1:0] s1_cur_reg, s1_smp_reg;
    logic [RW-1:0]           s1_row_reg;
    logic [CW-1:0]           s1_col_reg;
    logic signed [VAL_W-1:0] hist_a1_reg, hist_a2_reg, hist_b1_reg;

    logic [GW-1:0] rows_w, cols_w, rows_lim, cols_lim;
    logic [GW-1:0] col_w, row_w, nxt_col, nxt_row;
    logic [CW-1:0] cur_col, la_col;
    logic [RW-1:0] cur_row;
    logic          acc, s1_adv;

    logic [BW-1:0] b_up2, b_up1, b_ctr, b_dn1;
    logic [GW-1:0] row_s1, col_s1, ctr_row;
    logic          has_main, last_row, edge_row, edge_col;

    // Grid size saturated to the supported range
    always_comb
    begin
        rows_w = GW'(geom.grid_rows);
        cols_w = GW'(geom.grid_cols);
        if (rows_w < GW'(MIN_GRID))
            rows_lim = GW'(MIN_GRID);
        else if (rows_w > GW'(MAX_ROWS))
            rows_lim = GW'(MAX_ROWS);
        else
            rows_lim = rows_w;
        if (cols_w < GW'(MIN_GRID))
            cols_lim = GW'(MIN_GRID);
        else if (cols_w > GW'(MAX_COLS))
            cols_lim = GW'(MAX_COLS);
        else
            cols_lim = cols_w;
    end

    // Position of the arriving point (wraps if the grid shrank) and the one after it
    always_comb
    begin
        col_w = GW'(col_pos_reg);
        row_w = GW'(row_pos_reg);
        if (col_w >= cols_lim)
        begin
            col_w = '0;
            row_w = row_w + GW'(1);
        end
        if (row_w >= rows_lim)
            row_w = '0;
        nxt_col = col_w + GW'(1);
        nxt_row = row_w;
        if (nxt_col >= cols_lim)
        begin
            nxt_col = '0;
            nxt_row = row_w + GW'(1);
            if (nxt_row >= rows_lim)
                nxt_row = '0;
        end
    end

    assign cur_col      = col_w[CW-1:0];
    assign cur_row      = row_w[RW-1:0];
    assign la_col       = cur_col + CW'(2);
    assign col_pos_next = nxt_col[CW-1:0];
    assign row_pos_next = nxt_row[RW-1:0];

    // Handshake: one request waits in the read stage until the queue takes it
    assign s1_adv   = s1_valid_reg && (!has_main || !q_full);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign acc      = in_valid && !in_stall;
    assign q_push   = s1_valid_reg && has_main && !q_full;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (acc)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (acc)
            begin
                col_pos_reg <= col_pos_next;
                row_pos_reg <= row_pos_next;
            end
        end
    end

    // Row buffer access: read first, then overwrite the oldest row
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            for (int k = 0; k < ROW_BANKS; k++)
            begin
                rd_a_reg[k] <= cur_rows_mem[k][cur_col];
                rd_b_reg[k] <= cur_rows_mem[k][la_col];
            end
            cur_rows_mem[cur_row[BW-1:0]][cur_col] <= in_data.cur_value;
            prv_rd_reg <= prev_rows_mem[cur_row[0]][cur_col];
            prev_rows_mem[cur_row[0]][cur_col] <= in_data.prev_value;
            s1_row_reg <= cur_row;
            s1_col_reg <= cur_col;
            s1_cur_reg <= in_data.cur_value;
            s1_smp_reg <= in_data.source_sample;
        end
    end

    // Bank of each row relative to the arriving row
    assign b_up2 = s1_row_reg[BW-1:0];
    assign b_up1 = s1_row_reg[BW-1:0] + BW'(1);
    assign b_ctr = s1_row_reg[BW-1:0] + BW'(2);
    assign b_dn1 = s1_row_reg[BW-1:0] + BW'(3);

    // Horizontal neighbors of the center row: history of center and look-ahead reads
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            hist_a1_reg <= rd_a_reg[b_ctr];
            hist_a2_reg <= hist_a1_reg;
            hist_b1_reg <= rd_b_reg[b_ctr];
        end
    end

    // Classification of the center point
    always_comb
    begin
        row_s1   = GW'(s1_row_reg);
        col_s1   = GW'(s1_col_reg);
        ctr_row  = row_s1 - GW'(2);
        has_main = row_s1 >= GW'(2);
        last_row = row_s1 == rows_lim - GW'(1);
        edge_row = (ctr_row < EDGE_G) || (ctr_row + EDGE_G >= rows_lim);
        edge_col = (col_s1 < EDGE_G) || (col_s1 + EDGE_G >= cols_lim);
    end

    always_comb
    begin
        q_data.up2        = rd_a_reg[b_up2];
        q_data.up1        = rd_a_reg[b_up1];
        q_data.ctr        = rd_a_reg[b_ctr];
        q_data.dn1        = rd_a_reg[b_dn1];
        q_data.dn2        = s1_cur_reg;
        q_data.lf2        = hist_a2_reg;
        q_data.lf1        = hist_a1_reg;
        q_data.rt1        = hist_b1_reg;
        q_data.rt2        = rd_b_reg[b_ctr];
        q_data.prv        = prv_rd_reg;
        q_data.smp        = s1_smp_reg;
        q_data.row        = IDX_W'(s1_row_reg);
        q_data.col        = IDX_W'(s1_col_reg);
        q_data.last_row   = last_row;
        q_data.frame_last = last_row && (col_s1 == cols_lim - GW'(1));
        if (edge_row)
            q_data.main_kind = KIND_EDGE;
        else if (edge_col)
            q_data.main_kind = KIND_ZERO;
        else
            q_data.main_kind = KIND_INNER;
        q_data.main_src   = (ctr_row == GW'(geom.source_row)) &&
                            (col_s1 == GW'(geom.source_col));
    end

endmodule

`default_nettype wire

// ===== rtl/acws_queue.sv =====
// Short FIFO of window requests between front and back.
// Uses acws_pkg for the entry type and depth.
`default_nettype none

module acws_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  acws_pkg::q_entry_t push_data,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output acws_pkg::q_entry_t head_data
);
    import acws_pkg::*;

    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_entry_t         slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == CNT_W'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ===== rtl/acws_back.sv =====
// Back end: expands each window request into one to three points and runs the
// stencil / boundary arithmetic through a six-stage pipeline. Uses acws_pkg.
`default_nettype none

module acws_back (
    input  logic                clk,
    input  logic                rst_n,
    input  acws_pkg::gain_cfg_t gains,
    input  logic                head_valid,
    input  acws_pkg::q_entry_t  head_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output acws_pkg::out_item_t out_data
);
    import acws_pkg::*;

    // Which point of a request is being issued
    localparam logic [1:0] JOB_MAIN = 2'd0;   // row - 2
    localparam logic [1:0] JOB_UP   = 2'd1;   // row - 1, last row only
    localparam logic [1:0] JOB_SELF = 2'd2;   // row itself, last row only

    localparam logic signed [50:0] V_MAX = 51'sd2147483647;
    localparam logic signed [50:0] V_MIN = -51'sd2147483648;

    typedef struct packed {
        logic [1:0]       kind;
        logic             src;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             run_last;
        logic             frame_last;
    } meta_t;

    logic [1:0] sel_reg, sel_next;
    logic       en, issue, job_last;
    logic       a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg, f_valid_reg;

    meta_t                   job_meta;
    logic signed [VAL_W-1:0] job_u, job_below;

    // Stage A: selected job
    meta_t                   a_meta_reg;
    logic signed [VAL_W-1:0] a_u_reg, a_below_reg, a_prv_reg, a_smp_reg;
    logic signed [VAL_W-1:0] a_up1_reg, a_dn1_reg, a_lf1_reg, a_rt1_reg;
    logic signed [VAL_W-1:0] a_up2_reg, a_dn2_reg, a_lf2_reg, a_rt2_reg;
    // Stage B: partial sums
    meta_t                   b_meta_reg;
    logic signed [VAL_W-1:0] b_u_reg, b_prv_reg, b_smp_reg;
    logic signed [32:0]      b_diff_reg;
    logic signed [33:0]      b_near_reg, b_far_reg;
    logic signed [37:0]      b_u60_reg;
    // Stage C: multiplier operands
    meta_t                   c_meta_reg;
    logic signed [39:0]      c_x_reg, s_sum;
    logic [VAL_W-1:0]        c_g_reg;
    logic signed [33:0]      c_base_reg;
    logic signed [VAL_W-1:0] c_smp_reg;
    // Stage D: partial products
    meta_t                   d_meta_reg;
    logic signed [56:0]      d_phi_reg, d_plo_reg;
    logic signed [64:0]      d_psrc_reg;
    logic signed [33:0]      d_base_reg;
    logic signed [16:0]      g_hi, g_lo;
    logic signed [32:0]      sg_op;
    // Stage E: scaled terms
    meta_t                   e_meta_reg;
    logic signed [48:0]      e_t_reg;
    logic signed [40:0]      e_sq_reg;
    logic signed [33:0]      e_base_reg;
    logic signed [72:0]      prod;
    // Stage F: output register
    out_item_t               out_reg;
    logic signed [50:0]      v_sum;

    assign en        = !f_valid_reg || !out_stall;
    assign issue     = en && head_valid;
    assign job_last  = (sel_reg == JOB_SELF) || (sel_reg == JOB_MAIN && !head_data.last_row);
    assign pop       = issue && job_last;
    assign out_valid = f_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        sel_next = sel_reg;
        if (issue)
            sel_next = job_last ? JOB_MAIN : sel_reg + 2'd1;
    end

    // Job decoder: which value is the point, which lies below it
    always_comb
    begin
        job_meta.kind       = head_data.main_kind;
        job_meta.src        = head_data.main_src;
        job_meta.row        = head_data.row - IDX_W'(2);
        job_meta.col        = head_data.col;
        job_meta.run_last   = !head_data.last_row;
        job_meta.frame_last = 1'b0;
        job_u               = head_data.ctr;
        job_below           = head_data.dn1;
        unique case (sel_reg)
            JOB_MAIN:
            begin
                job_meta.kind = head_data.main_kind;
            end
            JOB_UP:
            begin
                job_meta.kind     = KIND_EDGE;
                job_meta.src      = 1'b0;
                job_meta.row      = head_data.row - IDX_W'(1);
                job_meta.run_last = 1'b0;
                job_u             = head_data.dn1;
                job_below         = head_data.dn2;
            end
            JOB_SELF:
            begin
                job_meta.kind       = KIND_EDGE;
                job_meta.src        = 1'b0;
                job_meta.row        = head_data.row;
                job_meta.run_last   = 1'b1;
                job_meta.frame_last = head_data.frame_last;
                job_u               = head_data.dn2;
                job_below           = head_data.dn2;
            end
            default:
            begin
                job_meta.kind = head_data.main_kind;
            end
        endcase
    end

    // Stage C combinational: stencil sum
    assign s_sum = (40'(b_near_reg) <<< 4) - 40'(b_far_reg) - 40'(b_u60_reg);

    // Stage D operands: gain split into two 16-bit halves
    assign g_hi  = signed'({1'b0, c_g_reg[31:16]});
    assign g_lo  = signed'({1'b0, c_g_reg[15:0]});
    assign sg_op = signed'({1'b0, gains.source_gain});

    // Stage E combinational: recombine halves
    assign prod = (73'(d_phi_reg) <<< 16) + 73'(d_plo_reg);

    // Stage F combinational: final sum per rule
    always_comb
    begin
        case (e_meta_reg.kind)
            KIND_INNER: v_sum = 51'(e_t_reg) + 51'(e_base_reg) - 51'(e_sq_reg);
            KIND_EDGE:  v_sum = 51'(e_base_reg) - 51'(e_t_reg);
            default:    v_sum = '0;
        endcase
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg     <= JOB_MAIN;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg <= sel_next;
            if (en)
            begin
                a_valid_reg <= head_valid;
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
                d_valid_reg <= c_valid_reg;
                e_valid_reg <= d_valid_reg;
                f_valid_reg <= e_valid_reg;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // A: job select
            a_meta_reg  <= job_meta;
            a_u_reg     <= job_u;
            a_below_reg <= job_below;
            a_prv_reg   <= head_data.prv;
            a_smp_reg   <= head_data.smp;
            a_up1_reg   <= head_data.up1;
            a_dn1_reg   <= head_data.dn1;
            a_lf1_reg   <= head_data.lf1;
            a_rt1_reg   <= head_data.rt1;
            a_up2_reg   <= head_data.up2;
            a_dn2_reg   <= head_data.dn2;
            a_lf2_reg   <= head_data.lf2;
            a_rt2_reg   <= head_data.rt2;
            // B: near/far sums, boundary difference, 60u
            b_meta_reg  <= a_meta_reg;
            b_u_reg     <= a_u_reg;
            b_prv_reg   <= a_prv_reg;
            b_smp_reg   <= a_smp_reg;
            b_diff_reg  <= 33'(a_below_reg) - 33'(a_u_reg);
            b_near_reg  <= 34'(a_up1_reg) + 34'(a_dn1_reg) + 34'(a_lf1_reg) + 34'(a_rt1_reg);
            b_far_reg   <= 34'(a_up2_reg) + 34'(a_dn2_reg) + 34'(a_lf2_reg) + 34'(a_rt2_reg);
            b_u60_reg   <= (38'(a_u_reg) <<< 6) - (38'(a_u_reg) <<< 2);
            // C: operand and gain select, base term
            c_meta_reg  <= b_meta_reg;
            c_smp_reg   <= b_smp_reg;
            if (b_meta_reg.kind == KIND_INNER)
            begin
                c_x_reg    <= s_sum;
                c_g_reg    <= gains.laplacian_gain;
                c_base_reg <= (34'(b_u_reg) <<< 1) - 34'(b_prv_reg);
            end
            else
            begin
                c_x_reg    <= 40'(b_diff_reg);
                c_g_reg    <= gains.courant_gain;
                c_base_reg <= 34'(b_u_reg);
            end
            // D: products
            d_meta_reg  <= c_meta_reg;
            d_base_reg  <= c_base_reg;
            d_phi_reg   <= c_x_reg * g_hi;
            d_plo_reg   <= c_x_reg * g_lo;
            d_psrc_reg  <= c_smp_reg * sg_op;
            // E: floor by 2^24
            e_meta_reg  <= d_meta_reg;
            e_base_reg  <= d_base_reg;
            e_t_reg     <= prod[72:24];
            if (d_meta_reg.src && d_meta_reg.kind == KIND_INNER)
                e_sq_reg <= d_psrc_reg[64:24];
            else
                e_sq_reg <= '0;
            // F: saturate into the output register
            out_reg.out_row    <= e_meta_reg.row;
            out_reg.out_col    <= e_meta_reg.col;
            out_reg.run_last   <= e_meta_reg.run_last;
            out_reg.frame_last <= e_meta_reg.frame_last;
            if (v_sum > V_MAX)
                out_reg.next_value <= V_MAX[31:0];
            else if (v_sum < V_MIN)
                out_reg.next_value <= V_MIN[31:0];
            else
                out_reg.next_value <= v_sum[31:0];
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/acws_checker.sv =====
// Scoreboard for acoustic_wave_stencil_2d: tracks register writes, predicts the
// next-value results of every accepted grid point and checks the output stream.
// Depends on acws_pkg for the payload structs and register indexes.
`timescale 1ns / 1ps

module acws_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [acws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [acws_pkg::VAL_W-1:0]     cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  acws_pkg::in_item_t             in_data,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  acws_pkg::out_item_t            out_data,
    output int                             errors,
    output int                             pending
);
    import acws_pkg::*;

    localparam int GRID_MAX = 1024;
    localparam int EDGE     = 3;

    // Shadow registers
    logic [31:0] lap_gain, cour_gain, src_gain;
    logic [9:0]  src_row, src_col;
    logic [10:0] rows_reg, cols_reg;

    // Shadow row buffers and raster position
    logic signed [31:0] cur_rows [4][GRID_MAX];
    logic signed [31:0] prev_rows [2][GRID_MAX];
    int unsigned        row_pos, col_pos;

    out_item_t next_values_q[$];

    assign pending = next_values_q.size();

    function automatic int unsigned clamp_size(logic [10:0] v);
        if (v < 7) return 7;
        if (v > GRID_MAX) return GRID_MAX;
        return v;
    endfunction

    // floor(s * g / 2^24), exact
    function automatic longint scale_q24(longint s, logic [31:0] g);
        logic signed [127:0] a, b, p;
        a = s;
        b = {96'b0, g};
        p = a * b;
        return longint'(p >>> 24);
    endfunction

    function automatic longint cur_at(int unsigned r, int unsigned c);
        return longint'(cur_rows[r % 4][c]);
    endfunction

    function automatic logic signed [31:0] wave_update(int unsigned i, int unsigned c,
        int unsigned nr, int unsigned nc, longint up2, longint pv, longint smp);
        longint u, s, v, below;
        u = cur_at(i, c);
        if (i < EDGE || i + EDGE >= nr) begin
            below = (i + 1 < nr) ? cur_at(i + 1, c) : u;
            v = u - scale_q24(below - u, cour_gain);
        end
        else if (c < EDGE || c + EDGE >= nc) begin
            v = 0;
        end
        else begin
            s = -(up2 + cur_at(i, c - 2))
                + 16 * (cur_at(i - 1, c) + cur_at(i, c - 1))
                - 60 * u
                + 16 * (cur_at(i + 1, c) + cur_at(i, c + 1))
                - (cur_at(i + 2, c) + cur_at(i, c + 2));
            v = scale_q24(s, lap_gain) + 2 * u - pv;
            if (i == src_row && c == src_col) v -= scale_q24(smp, src_gain);
        end
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return 32'(v);
    endfunction

    // Predict the results of one accepted point
    task automatic predict_point(in_item_t d);
        int unsigned nr, nc, r, c;
        longint oldest, p2, smp;
        out_item_t res [3];
        int n;
        nr = clamp_size(rows_reg);
        nc = clamp_size(cols_reg);
        n = 0;
        if (col_pos >= nc) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= nr) row_pos = 0;
        r = row_pos;
        c = col_pos;
        smp = longint'(d.source_sample);
        oldest = cur_at(r, c);
        p2 = longint'(prev_rows[r % 2][c]);
        cur_rows[r % 4][c] = d.cur_value;
        prev_rows[r % 2][c] = d.prev_value;
        if (r >= 2) begin
            res[n] = '{wave_update(r - 2, c, nr, nc, oldest, p2, smp), 10'(r - 2), 10'(c), 0, 0};
            n++;
        end
        if (r == nr - 1) begin
            res[n] = '{wave_update(r - 1, c, nr, nc, 0, 0, smp), 10'(r - 1), 10'(c), 0, 0};
            n++;
            res[n] = '{wave_update(r, c, nr, nc, 0, 0, smp), 10'(r), 10'(c), 0, 0};
            n++;
            if (c == nc - 1) res[n - 1].frame_last = 1'b1;
        end
        if (n > 0) res[n - 1].run_last = 1'b1;
        for (int k = 0; k < n; k++) next_values_q.push_back(res[k]);
        col_pos = c + 1;
        if (col_pos >= nc) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= nr) row_pos = 0;
        end
    endtask

    initial
    begin
        errors = 0;
        for (int b = 0; b < 4; b++)
            for (int k = 0; k < GRID_MAX; k++) cur_rows[b][k] = '0;
        for (int b = 0; b < 2; b++)
            for (int k = 0; k < GRID_MAX; k++) prev_rows[b][k] = '0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n) begin
            lap_gain  = '0;
            cour_gain = '0;
            src_gain  = '0;
            src_row   = '0;
            src_col   = '0;
            rows_reg  = 11'd300;
            cols_reg  = 11'd300;
            row_pos   = 0;
            col_pos   = 0;
            next_values_q.delete();
        end
        else begin
            // Register writes
            if (cfg_write) begin
                case (cfg_index)
                    REG_LAPLACIAN_GAIN: lap_gain  = cfg_data;
                    REG_COURANT_GAIN:   cour_gain = cfg_data;
                    REG_SOURCE_GAIN:    src_gain  = cfg_data;
                    REG_SOURCE_ROW:     src_row   = cfg_data[9:0];
                    REG_SOURCE_COL:     src_col   = cfg_data[9:0];
                    REG_GRID_ROWS:      rows_reg  = cfg_data[10:0];
                    REG_GRID_COLS:      cols_reg  = cfg_data[10:0];
                    default: ;
                endcase
            end
            // Results leaving the block
            if (out_valid && !out_stall) begin
                if (next_values_q.size() == 0) begin
                    $error("unexpected result row %0d col %0d", out_data.out_row,
                           out_data.out_col);
                    errors++;
                end
                else begin
                    want = next_values_q.pop_front();
                    if (out_data.next_value !== want.next_value) begin
                        $error("next_value: expected %0d, got %0d", want.next_value,
                               out_data.next_value);
                        errors++;
                    end
                    if (out_data.out_row !== want.out_row) begin
                        $error("out_row: expected %0d, got %0d", want.out_row,
                               out_data.out_row);
                        errors++;
                    end
                    if (out_data.out_col !== want.out_col) begin
                        $error("out_col: expected %0d, got %0d", want.out_col,
                               out_data.out_col);
                        errors++;
                    end
                    if (out_data.run_last !== want.run_last) begin
                        $error("run_last: expected %0b, got %0b", want.run_last,
                               out_data.run_last);
                        errors++;
                    end
                    if (out_data.frame_last !== want.frame_last) begin
                        $error("frame_last: expected %0b, got %0b", want.frame_last,
                               out_data.frame_last);
                        errors++;
                    end
                end
            end
            // Points entering the block
            if (in_valid && !in_stall) predict_point(in_data);
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the acoustic_wave_stencil_2d testbench: clock, reset, register setup,
// grid-point stimulus with random idling. Depends on acws_pkg and acws_checker.
`timescale 1ns / 1ps

module testbench;
    import acws_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VAL_W-1:0]     cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_data;
    int          errors, pending;
    int          cycles = 0;
    bit          idle_on = 1'b0;
    int          random_points = 0;

    always #6 clk = ~clk;

    acoustic_wave_stencil_2d i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    acws_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .errors(errors), .pending(pending)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL acoustic_wave_stencil_2d");
            $finish;
        end
    end

    // Receiver stall bursts
    always @(posedge clk)
    begin
        if (idle_on && $urandom_range(0, 7) == 0) begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        out_stall <= 1'b0;
    end

    // Field value: often extreme, sometimes fully random or modest
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4, 5: return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0100_0000;
            3: return $urandom;
            default: return $urandom_range(0, 32'h0040_0000);
        endcase
    endfunction

    // One register write; caller lowers the write enable after a batch
    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic setup_step(logic [31:0] lap, logic [31:0] cour, logic [31:0] srcg,
                              logic [9:0] srow, logic [9:0] scol,
                              logic [10:0] nrows, logic [10:0] ncols);
        put_reg(REG_LAPLACIAN_GAIN, lap);
        put_reg(REG_COURANT_GAIN, cour);
        put_reg(REG_SOURCE_GAIN, srcg);
        put_reg(REG_SOURCE_ROW, {22'b0, srow});
        put_reg(REG_SOURCE_COL, {22'b0, scol});
        put_reg(REG_GRID_ROWS, {21'b0, nrows});
        put_reg(REG_GRID_COLS, {21'b0, ncols});
        cfg_write <= 1'b0;
    endtask

    // Send one grid point, valid stays high into the next request
    task automatic send_point(in_item_t d);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= d;
        do @(posedge clk); while (in_stall);
    endtask

    // Wait for the block to go quiet
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic int eff_size(logic [10:0] v);
        return (v < 7) ? 7 : ((v > 1024) ? 1024 : v);
    endfunction

    // Stream one whole frame; directed frames cycle through extreme values
    task automatic send_frame(int npoints, bit directed);
        in_item_t d;
        logic [31:0] corner [4];
        corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        for (int k = 0; k < npoints; k++) begin
            if (directed) begin
                d.cur_value = corner[k % 4];
                d.prev_value = corner[(k / 4) % 4];
                d.source_sample = corner[(k / 16) % 4];
            end
            else begin
                d.cur_value = pick_value();
                d.prev_value = pick_value();
                d.source_sample = pick_value();
            end
            send_point(d);
        end
        drain();
    endtask

    initial
    begin
        logic [10:0] nr, nc, wr_rows, wr_cols;
        int npts;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: smallest grid, source at the lone interior point
        setup_step(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd3, 10'd3, 11'd7, 11'd7);
        send_frame(49, 1'b1);
        // Directed: zero gains, undersized grid registers, source out of the interior
        setup_step(32'h0, 32'h0, 32'h0, 10'd1023, 10'd1023, 11'd0, 11'd0);
        send_frame(49, 1'b1);

        // Random frames with idling on both sides
        idle_on = 1'b1;
        while (random_points < 180) begin
            nr = $urandom_range(7, 12);
            nc = $urandom_range(7, 12);
            wr_rows = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 6)) : nr;
            wr_cols = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 6)) : nc;
            setup_step(pick_gain(), pick_gain(), pick_gain(),
                       ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(3, nr - 4)),
                       ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(3, nc - 4)),
                       wr_rows, wr_cols);
            npts = eff_size(wr_rows) * eff_size(wr_cols);
            send_frame(npts, 1'b0);
            random_points += npts;
        end

        // Closing frame, no idling
        idle_on = 1'b0;
        setup_step(pick_gain(), pick_gain(), pick_gain(), 10'd3, 10'd3, 11'd7, 11'd7);
        send_frame(49, 1'b0);

        if (errors == 0 && pending == 0)
            $display("PASS acoustic_wave_stencil_2d");
        else
            $display("FAIL acoustic_wave_stencil_2d");
        $finish;
    end

endmodule

// ===== acoustic_wave_stencil_2d.f =====
rtl/acws_pkg.sv
rtl/acws_front.sv
rtl/acws_queue.sv
rtl/acws_back.sv
rtl/acoustic_wave_stencil_2d.sv
tb/sv/acws_checker.sv
tb/sv/testbench.sv
